// ----- hdl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the stereo feedback delay: sample and gain
// formats, register indexes, reset values and the channel payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

   // sample and gain formats
   localparam int SAMPLE_BITS           = 24;
   localparam int GAIN_BITS             = 16;
   localparam int GAIN_FRAC_BITS        = 15;
   localparam int DELAY_BITS            = 16;
   localparam int HISTORY_DEPTH_DEFAULT = 65536;

   // register port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register reset values
   localparam logic [DELAY_BITS-1:0] DELAY_RESET    = 16'd5512;
   localparam logic [GAIN_BITS-1:0]  DRY_RESET      = 16'd32768;
   localparam logic [GAIN_BITS-1:0]  WET_RESET      = 16'd24576;
   localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET = 16'd16384;

   typedef enum logic [1:0] {
      REG_DELAY,
      REG_DRY_GAIN,
      REG_WET_GAIN,
      REG_FEEDBACK_GAIN
   } reg_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [GAIN_BITS-1:0]          gain_type;

   typedef struct packed {
      sample_type left_in;
      sample_type right_in;
   } req_type;

   typedef struct packed {
      sample_type left_out;
      sample_type right_out;
   } rsp_type;

   typedef struct packed {
      gain_type dry;
      gain_type wet;
      gain_type feedback;
   } gain_set_type;

   // how the delayed sample is sourced in the first datapath stage
   typedef struct packed {
      logic hist_valid;   // entry has been written since reset
      logic fwd_hit;      // entry was written at the same edge it was read
   } read_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/sfd_ram.sv -----
// ----------------------------------------------------------------------------
// sfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read of the entry written at the same edge returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/sfd_channel.sv -----
// ----------------------------------------------------------------------------
// sfd_channel
// One channel of the echo datapath: pick the delayed sample, scale it and
// the input by the Q1.15 gains, then sum and saturate the stored value and
// the output sample.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_channel (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire sfd_pkg::sample_type   sample_in,
   input  wire sfd_pkg::sample_type   hist_rdata,
   input  wire sfd_pkg::sample_type   fwd_data,
   input  wire sfd_pkg::read_ctl_type ctl,
   input  wire sfd_pkg::gain_set_type gain,
   output sfd_pkg::sample_type        store_value,
   output sfd_pkg::sample_type        result_value
);

   localparam int SB       = sfd_pkg::SAMPLE_BITS;
   localparam int PROD_W   = SB + sfd_pkg::GAIN_BITS + 1;
   localparam int SCALED_W = PROD_W - sfd_pkg::GAIN_FRAC_BITS;
   localparam int SUM_W    = SCALED_W + 1;

   sfd_pkg::sample_type          delayed;
   logic signed [sfd_pkg::GAIN_BITS:0] dry_s;
   logic signed [sfd_pkg::GAIN_BITS:0] wet_s;
   logic signed [sfd_pkg::GAIN_BITS:0] fb_s;
   logic signed [PROD_W-1:0]     prod_dry;
   logic signed [PROD_W-1:0]     prod_wet;
   logic signed [PROD_W-1:0]     prod_fb;
   logic signed [SCALED_W-1:0]   dry_in, wet_in, fb_in;
   logic signed [SCALED_W-1:0]   dry_ff, wet_ff, fb_ff;
   sfd_pkg::sample_type          in2_in, in2_ff;
   logic signed [SUM_W-1:0]      store_sum;
   logic signed [SUM_W-1:0]      result_sum;

   // clamp a wide sum to the sample range
   function automatic sfd_pkg::sample_type saturate(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-SB:0] top;
      sfd_pkg::sample_type res;
      top = v[SUM_W-1:SB-1];
      if (top == '0 || top == '1) begin
         res = v[SB-1:0];
      end else if (v[SUM_W-1]) begin
         res = {1'b1, {(SB-1){1'b0}}};
      end else begin
         res = {1'b0, {(SB-1){1'b1}}};
      end
      return res;
   endfunction

   // select the delayed sample: zero before first write, forwarded on a same-edge write
   always_comb begin
      if (!ctl.hist_valid) begin
         delayed = '0;
      end else if (ctl.fwd_hit) begin
         delayed = fwd_data;
      end else begin
         delayed = hist_rdata;
      end
   end

   // scale by the gains, drop the fraction bits (floor)
   assign dry_s    = $signed({1'b0, gain.dry});
   assign wet_s    = $signed({1'b0, gain.wet});
   assign fb_s     = $signed({1'b0, gain.feedback});
   assign prod_dry = PROD_W'(sample_in) * PROD_W'(dry_s);
   assign prod_wet = PROD_W'(delayed) * PROD_W'(wet_s);
   assign prod_fb  = PROD_W'(delayed) * PROD_W'(fb_s);
   assign dry_in   = prod_dry[PROD_W-1:sfd_pkg::GAIN_FRAC_BITS];
   assign wet_in   = prod_wet[PROD_W-1:sfd_pkg::GAIN_FRAC_BITS];
   assign fb_in    = prod_fb[PROD_W-1:sfd_pkg::GAIN_FRAC_BITS];
   assign in2_in   = sample_in;

   // hold the scaled terms for the summing stage
   always_ff @(posedge clock) begin
      if (load) begin
         dry_ff <= dry_in;
         wet_ff <= wet_in;
         fb_ff  <= fb_in;
         in2_ff <= in2_in;
      end
   end

   // sum and saturate
   assign store_sum    = SUM_W'(in2_ff) + SUM_W'(fb_ff);
   assign result_sum   = SUM_W'(dry_ff) + SUM_W'(wet_ff);
   assign store_value  = saturate(store_sum);
   assign result_value = saturate(result_sum);

endmodule

`default_nettype wire

// ----- hdl/stereo_feedback_delay.sv -----
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback echo: each frame reads the history entry a programmed
// number of frames back, stores input plus scaled echo, outputs mixed sound.
// ----------------------------------------------------------------------------
// Takes one stereo frame per clock while req_stall is low, returns one result
// frame for each input transfer (read, scale, sum and write back). The history
// of each channel lives in its own RAM with registered read; the write back
// comes from stage 2, and a read of the entry being written at that edge is
// forwarded. When the delay is one frame (modulo the history depth) each frame
// needs the stored value of the frame just before it, so the feedback loop
// through the RAM holds each frame until the one before it has left stage 1;
// any other delay runs at one frame per cycle while the result queue has room.
// A four-entry result queue lets frames keep flowing while rsp_stall is high
// until it fills. History entries not yet written since reset read as zero,
// tracked by the write pointer and a wrap flag, so no clearing pass runs after
// reset. The delay register is taken modulo the history depth when written.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_delay #(
   parameter int HISTORY_DEPTH = sfd_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input frames
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sfd_pkg::req_type                    req_data,
   // result frames
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sfd_pkg::rsp_type                         rsp_data,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [sfd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sfd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [sfd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);

   localparam int ADDR_W    = $clog2(HISTORY_DEPTH);
   localparam int DELAY_MAX = (2 ** sfd_pkg::DELAY_BITS) - 1;
   localparam int QUOT_MAX  = DELAY_MAX / HISTORY_DEPTH;
   localparam int MOD_STEPS = $clog2(QUOT_MAX + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OCC_W     = $clog2(OUT_DEPTH + 1);
   localparam int GB        = sfd_pkg::GAIN_BITS;

   // delay modulo the history depth, restoring subtraction
   function automatic logic [ADDR_W-1:0] reduce_delay(
      input logic [sfd_pkg::DELAY_BITS-1:0] v);
      logic [sfd_pkg::DELAY_BITS-1:0] r;
      r = v;
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (32'(r) >= (32'(HISTORY_DEPTH) << k)) begin
            r = r - sfd_pkg::DELAY_BITS'(32'(HISTORY_DEPTH) << k);
         end
      end
      return ADDR_W'(r);
   endfunction

   // register port
   logic                                 csr_write;
   sfd_pkg::reg_index_type               csr_index;
   logic [sfd_pkg::DELAY_BITS-1:0]       delay_in, delay_ff;
   logic [ADDR_W-1:0]                    delay_mod_in, delay_mod_ff;
   sfd_pkg::gain_set_type                gain_in, gain_ff;

   // front end
   logic                                 req_accept;
   logic [ADDR_W:0]                      rd_diff;
   logic [ADDR_W-1:0]                    rd_addr;
   logic                                 hazard;
   logic [ADDR_W-1:0]                    wr_ptr_in, wr_ptr_ff;
   logic                                 wrapped_in, wrapped_ff;

   // stage 1 (RAM data out, multiply)
   logic                                 v1_in, v1_ff;
   logic [ADDR_W-1:0]                    wr1_in, wr1_ff;
   sfd_pkg::req_type                     in1_ff;
   sfd_pkg::read_ctl_type                ctl1_in, ctl1_ff;

   // stage 2 (sum, write back)
   logic                                 v2_in, v2_ff;
   logic [ADDR_W-1:0]                    wr2_in, wr2_ff;

   // last write, forwarded to a read at the same edge
   logic [ADDR_W-1:0]                    lw_addr_ff;
   sfd_pkg::sample_type                  lw_left_ff, lw_right_ff;

   // history RAM ports and datapath results
   sfd_pkg::sample_type                  left_rdata, right_rdata;
   sfd_pkg::sample_type                  left_store, right_store;
   sfd_pkg::sample_type                  left_result, right_result;

   // result queue
   sfd_pkg::rsp_type                     out_q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]                 out_wp_in, out_wp_ff;
   logic [OUT_PTR_W-1:0]                 out_rp_in, out_rp_ff;
   logic [OCC_W-1:0]                     out_cnt_in, out_cnt_ff;
   logic [OCC_W-1:0]                     occ_in, occ_ff;
   logic                                 rsp_transfer;

   // register writes and reads
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = sfd_pkg::reg_index_type'(paddr[sfd_pkg::CSR_ADDR_BITS-1:2]);

   always_comb begin
      delay_in     = delay_ff;
      delay_mod_in = delay_mod_ff;
      gain_in      = gain_ff;
      if (csr_write) begin
         case (csr_index)
            sfd_pkg::REG_DELAY: begin
               delay_in     = pwdata[sfd_pkg::DELAY_BITS-1:0];
               delay_mod_in = reduce_delay(pwdata[sfd_pkg::DELAY_BITS-1:0]);
            end
            sfd_pkg::REG_DRY_GAIN: begin
               gain_in.dry = pwdata[GB-1:0];
            end
            sfd_pkg::REG_WET_GAIN: begin
               gain_in.wet = pwdata[GB-1:0];
            end
            sfd_pkg::REG_FEEDBACK_GAIN: begin
               gain_in.feedback = pwdata[GB-1:0];
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sfd_pkg::REG_DELAY:         prdata = sfd_pkg::CSR_DATA_BITS'(delay_ff);
         sfd_pkg::REG_DRY_GAIN:      prdata = sfd_pkg::CSR_DATA_BITS'(gain_ff.dry);
         sfd_pkg::REG_WET_GAIN:      prdata = sfd_pkg::CSR_DATA_BITS'(gain_ff.wet);
         sfd_pkg::REG_FEEDBACK_GAIN: prdata = sfd_pkg::CSR_DATA_BITS'(gain_ff.feedback);
         default:                    prdata = '0;
      endcase
   end

   // read address: write pointer minus delay, wrapped into the history
   assign rd_diff = {1'b0, wr_ptr_ff} - {1'b0, delay_mod_ff};
   assign rd_addr = rd_diff[ADDR_W]
                  ? ADDR_W'(rd_diff + (ADDR_W + 1)'(HISTORY_DEPTH))
                  : rd_diff[ADDR_W-1:0];

   // hold input while the frame in stage 1 still has to write the entry we need
   assign hazard     = v1_ff && (rd_addr == wr1_ff);
   assign req_stall  = (occ_ff == OCC_W'(OUT_DEPTH)) || hazard;
   assign req_accept = req_valid && !req_stall;

   // pipeline control and pointers
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      wrapped_in = wrapped_ff;
      if (req_accept) begin
         if (wr_ptr_ff == ADDR_W'(HISTORY_DEPTH - 1)) begin
            wr_ptr_in  = '0;
            wrapped_in = 1'b1;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      v1_in              = req_accept;
      wr1_in             = wr_ptr_ff;
      ctl1_in.hist_valid = wrapped_ff || (rd_addr < wr_ptr_ff);
      ctl1_in.fwd_hit    = v2_ff && (wr2_ff == rd_addr);
      v2_in              = v1_ff;
      wr2_in             = wr1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= sfd_pkg::DELAY_RESET;
         delay_mod_ff <= reduce_delay(sfd_pkg::DELAY_RESET);
         gain_ff      <= '{dry:      sfd_pkg::DRY_RESET,
                           wet:      sfd_pkg::WET_RESET,
                           feedback: sfd_pkg::FEEDBACK_RESET};
         wr_ptr_ff    <= '0;
         wrapped_ff   <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         delay_mod_ff <= delay_mod_in;
         gain_ff      <= gain_in;
         wr_ptr_ff    <= wr_ptr_in;
         wrapped_ff   <= wrapped_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      wr1_ff  <= wr1_in;
      wr2_ff  <= wr2_in;
      ctl1_ff <= ctl1_in;
      if (req_accept) begin
         in1_ff <= req_data;
      end
      if (v2_ff) begin
         lw_addr_ff  <= wr2_ff;
         lw_left_ff  <= left_store;
         lw_right_ff <= right_store;
      end
   end

   // history memories
   sfd_ram #(
      .WIDTH (sfd_pkg::SAMPLE_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_left_hist (
      .clock   (clock),
      .wr_en   (v2_ff),
      .wr_addr (wr2_ff),
      .wr_data (left_store),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (left_rdata)
   );

   sfd_ram #(
      .WIDTH (sfd_pkg::SAMPLE_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_right_hist (
      .clock   (clock),
      .wr_en   (v2_ff),
      .wr_addr (wr2_ff),
      .wr_data (right_store),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (right_rdata)
   );

   // channel datapaths
   sfd_channel u_left (
      .clock        (clock),
      .load         (v1_ff),
      .sample_in    (in1_ff.left_in),
      .hist_rdata   (left_rdata),
      .fwd_data     (lw_left_ff),
      .ctl          (ctl1_ff),
      .gain         (gain_ff),
      .store_value  (left_store),
      .result_value (left_result)
   );

   sfd_channel u_right (
      .clock        (clock),
      .load         (v1_ff),
      .sample_in    (in1_ff.right_in),
      .hist_rdata   (right_rdata),
      .fwd_data     (lw_right_ff),
      .ctl          (ctl1_ff),
      .gain         (gain_ff),
      .store_value  (right_store),
      .result_value (right_result)
   );

   // result queue: push from stage 2, pop on output transfer
   assign rsp_valid    = (out_cnt_ff != '0);
   assign rsp_data     = out_q_ff[out_rp_ff];
   assign rsp_transfer = rsp_valid && !rsp_stall;

   always_comb begin
      out_wp_in  = v2_ff ? out_wp_ff + 1'b1 : out_wp_ff;
      out_rp_in  = rsp_transfer ? out_rp_ff + 1'b1 : out_rp_ff;
      out_cnt_in = out_cnt_ff + OCC_W'(v2_ff) - OCC_W'(rsp_transfer);
      occ_in     = occ_ff + OCC_W'(req_accept) - OCC_W'(rsp_transfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= '0;
         out_rp_ff  <= '0;
         out_cnt_ff <= '0;
         occ_ff     <= '0;
      end else begin
         out_wp_ff  <= out_wp_in;
         out_rp_ff  <= out_rp_in;
         out_cnt_ff <= out_cnt_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         out_q_ff[out_wp_ff] <= '{left_out: left_result, right_out: right_result};
      end
   end

   // frames in flight plus queued results match the credit count
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occ_ff == out_cnt_ff + OCC_W'(v1_ff) + OCC_W'(v2_ff))
      else $error("frame occupancy out of step with pipeline and queue");

   // credit count never exceeds the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(OUT_DEPTH))
      else $error("result queue overcommitted");

   // stage 1 never reads the entry that stage 2 is about to write
   a_no_raw: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff) |-> ($past(rd_addr) != wr2_ff))
      else $error("read of an entry still being written");

   // a forwarded read matches the address written at the read edge
   a_fwd_addr: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && ctl1_ff.fwd_hit) |-> (lw_addr_ff == $past(rd_addr)))
      else $error("forwarded data from the wrong entry");

endmodule

`default_nettype wire

// ----- tb/stereo_feedback_delay_tb.sv -----
// ----------------------------------------------------------------------------
// stereo_feedback_delay_tb
// Streams stereo frames through the echo block under random valid and stall
// gaps, models both history memories and the register set, and checks each
// result frame field by field, in order, against the predicted mix.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfd_pkg::*;

   localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT;
   localparam int FRAMES_PER_PHASE = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER = 120;
   localparam sample_type SAMPLE_MAX = 24'sh7FFFFF;
   localparam sample_type SAMPLE_MIN = 24'sh800000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_BITS-1:0]  paddr;
   logic [CSR_DATA_BITS-1:0]  pwdata;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   // predictor state: register copies, echo memories and write pointer
   logic [DELAY_BITS-1:0]     cfg_delay;
   gain_type                  cfg_dry;
   gain_type                  cfg_wet;
   gain_type                  cfg_feedback;
   sample_type                echo_mem [2][HISTORY_DEPTH];
   int                        echo_wr_ptr;

   req_type                   pending_frames [$];
   rsp_type                   expected_mix [$];
   int                        mismatch_count;
   int                        results_seen;
   bit                        req_accepted;
   bit                        rsp_accepted;
   int                        calm_left [2];
   int                        send_gap;
   int                        stall_cycles;
   int                        hold_cycles;
   bit                        long_hold_done;

   stereo_feedback_delay uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // sample times unsigned Q1.15 gain, low bits dropped toward minus infinity
   function automatic longint scale_q15(longint sample, gain_type gain);
      longint product;
      product = sample * longint'(gain);
      return product >>> GAIN_FRAC_BITS;
   endfunction

   function automatic sample_type clip(longint value);
      if (value > longint'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end
      if (value < longint'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return sample_type'(value);
   endfunction

   // read the tap before overwriting, so a zero delay sees the oldest entry
   function automatic sample_type mix_channel(int ch, int rd, sample_type din);
      longint tap;
      tap = longint'(echo_mem[ch][rd]);
      echo_mem[ch][echo_wr_ptr] = clip(longint'(din) + scale_q15(tap, cfg_feedback));
      return clip(scale_q15(longint'(din), cfg_dry) + scale_q15(tap, cfg_wet));
   endfunction

   function automatic rsp_type predict_echo(req_type frame);
      rsp_type mix;
      int rd;
      rd = (echo_wr_ptr + HISTORY_DEPTH - (int'(cfg_delay) % HISTORY_DEPTH)) % HISTORY_DEPTH;
      mix.left_out = mix_channel(0, rd, frame.left_in);
      mix.right_out = mix_channel(1, rd, frame.right_in);
      echo_wr_ptr = (echo_wr_ptr + 1) % HISTORY_DEPTH;
      return mix;
   endfunction

   function automatic gain_type register_value(reg_index_type idx);
      case (idx)
         REG_DELAY:    return cfg_delay;
         REG_DRY_GAIN: return cfg_dry;
         REG_WET_GAIN: return cfg_wet;
         default:      return cfg_feedback;
      endcase
   endfunction

   // mostly short waits, now and then a run of back-to-back transfers
   function automatic int draw_wait(int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left[side] = $urandom_range(20, 60);
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2:    return sample_type'(int'($urandom_range(0, 8191)) - 4096);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic gain_type random_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd32768;
         2:       return 16'hFFFF;
         default: return gain_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // one APB transfer: setup cycle, then access cycle until pready
   task automatic csr_access(bit is_write, reg_index_type idx, gain_type wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= CSR_ADDR_BITS'(int'(idx) * 4);
      pwdata <= CSR_DATA_BITS'(wdata);
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_register(reg_index_type idx);
      logic [CSR_DATA_BITS-1:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata[GAIN_BITS-1:0] !== register_value(idx)) begin
         report_mismatch($sformatf("register %s reads %h, expected %h",
                                   idx.name(), rdata, register_value(idx)));
      end
   endtask

   task automatic program_register(reg_index_type idx, gain_type value);
      logic [CSR_DATA_BITS-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         REG_DELAY:    cfg_delay = value;
         REG_DRY_GAIN: cfg_dry = value;
         REG_WET_GAIN: cfg_wet = value;
         default:      cfg_feedback = value;
      endcase
      check_register(idx);
   endtask

   task automatic set_registers(gain_type delay, gain_type dry, gain_type wet,
                                gain_type feedback);
      program_register(REG_DELAY, delay);
      program_register(REG_DRY_GAIN, dry);
      program_register(REG_WET_GAIN, wet);
      program_register(REG_FEEDBACK_GAIN, feedback);
   endtask

   task automatic push_frame(sample_type left, sample_type right);
      pending_frames.push_back(req_type'{left_in: left, right_in: right});
   endtask

   // wait until every frame is sent, then until every result has come back
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_frames.size() != 0 || req_valid);
      do begin
         @(negedge clock);
      end while (expected_mix.size() != 0);
   endtask

   // predict on every input transfer, check on every result transfer
   always @(posedge clock) begin
      req_accepted = !reset && req_valid && !req_stall;
      rsp_accepted = !reset && rsp_valid && !rsp_stall;
      if (req_accepted) begin
         expected_mix.push_back(predict_echo(req_data));
      end
      if (rsp_accepted) begin
         results_seen++;
         if (expected_mix.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            rsp_type want;
            want = expected_mix.pop_front();
            if (rsp_data.left_out !== want.left_out) begin
               report_mismatch($sformatf("result %0d left_out %h, expected %h",
                                         results_seen, rsp_data.left_out, want.left_out));
            end
            if (rsp_data.right_out !== want.right_out) begin
               report_mismatch($sformatf("result %0d right_out %h, expected %h",
                                         results_seen, rsp_data.right_out, want.right_out));
            end
         end
      end
   end

   // sender: hold a stalled frame, else wait out the gap, then offer the next
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_accepted)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_frames.size() != 0) begin
            req_data <= pending_frames.pop_front();
            req_valid <= 1'b1;
            send_gap = draw_wait(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall after each transfer, one long hold-off mid run
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_cycles = LONG_HOLD_CYCLES;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (rsp_accepted) begin
               stall_cycles = draw_wait(1);
            end
            if (stall_cycles > 0) begin
               stall_cycles--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatch_count = 0;
      results_seen = 0;
      send_gap = 0;
      stall_cycles = 0;
      hold_cycles = 0;
      long_hold_done = 1'b0;
      calm_left = '{0, 0};
      echo_wr_ptr = 0;
      cfg_delay = DELAY_RESET;
      cfg_dry = DRY_RESET;
      cfg_wet = WET_RESET;
      cfg_feedback = FEEDBACK_RESET;
      foreach (echo_mem[ch, i]) begin
         echo_mem[ch][i] = '0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values, then a few frames through the reset setting
      for (int i = 0; i < 4; i++) begin
         check_register(reg_index_type'(i));
      end
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame('0, '1);
      wait_idle();

      // one-frame delay with every gain near 2.0: drive stores and outputs to saturation
      set_registers(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame('1, '0);
      push_frame('0, '1);
      push_frame(24'shAAAAAA, 24'sh555555);
      push_frame(24'sh555555, 24'shAAAAAA);
      push_frame('0, '0);
      push_frame('0, '0);
      wait_idle();

      // zero delay reads the entry about to be overwritten
      set_registers(16'd0, 16'd0, 16'd32768, 16'd32768);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(24'sh123456, 24'shEDCBA9);
      push_frame('1, SAMPLE_MAX);
      push_frame(SAMPLE_MIN, '0);
      wait_idle();

      // longest delay, echo muted
      set_registers(16'hFFFF, 16'd32768, 16'd0, 16'd0);
      push_frame(SAMPLE_MAX, '1);
      push_frame(SAMPLE_MIN, 24'sh000001);
      push_frame(24'sh400000, 24'shC00000);
      push_frame('0, SAMPLE_MIN);
      wait_idle();

      // short delay with near-unity feedback so echoes pile up
      set_registers(16'd2, 16'd16384, 16'd32768, 16'd32767);
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
      push_frame(24'sh000007, 24'shFFFFF9);
      push_frame(24'sh3FFFFF, 24'shC00001);
      wait_idle();

      // random phases, each with its own delay and gains
      for (int phase = 0; phase < 6; phase++) begin
         gain_type delay;
         case (phase)
            0:       delay = 16'd1;
            1:       delay = gain_type'($urandom_range(2, 12));
            2:       delay = 16'd0;
            3:       delay = gain_type'($urandom_range(13, 64));
            4:       delay = gain_type'($urandom_range(200, 700));
            default: delay = gain_type'($urandom_range(1, 65535));
         endcase
         set_registers(delay, random_gain(), random_gain(), random_gain());
         repeat (FRAMES_PER_PHASE) begin
            push_frame(random_sample(), random_sample());
         end
         wait_idle();
      end

      // let any stray result show up before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- stereo_feedback_delay.f -----
hdl/sfd_pkg.sv
hdl/sfd_ram.sv
hdl/sfd_channel.sv
hdl/stereo_feedback_delay.sv
tb/stereo_feedback_delay_tb.sv
